// ===== rtl/tlik_pkg.sv =====
// Shared types, widths and constants for the two-link inverse kinematics solver.
// Used by every module in rtl/; no dependencies.
package tlik_pkg;

  localparam int XW   = 16;  // target x, unsigned
  localparam int YW   = 17;  // target y, signed
  localparam int LW   = 15;  // link lengths
  localparam int SHW  = 16;  // shoulder angle out
  localparam int ELW  = 14;  // elbow angle out
  localparam int NUMW = 35;  // signed law-of-cosines numerators
  localparam int DENW = 31;  // 2*l1*l2
  localparam int RADW = 62;  // radicand of the triangle area term
  localparam int ROOTW = 31;
  localparam int ISQ_STAGES = RADW / 2;
  localparam int CX_W = 58;  // CORDIC x/y datapath
  localparam int ZW   = 25;  // CORDIC angle, 2^-16 degree
  localparam int PRESHIFT = 20;
  localparam int TABLE_LEN = 24;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_FRAC_BITS = 6;

  localparam logic [LW-1:0] LINK_RESET = 15'd2560;

  localparam logic CFG_UPPER = 1'b0;
  localparam logic CFG_LOWER = 1'b1;

  localparam logic signed [ZW-1:0] DEG90  = 25'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 25'sd11796480;

  typedef struct packed {
    logic                   reach;
    logic signed [NUMW-1:0] num_e;
    logic signed [NUMW-1:0] num_s;
    logic [DENW-1:0]        den;
    logic [XW-1:0]          tx;
    logic [YW-1:0]          ay;
    logic                   yneg;
  } item_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 25'sd2949120;
      1:  r = 25'sd1740967;
      2:  r = 25'sd919879;
      3:  r = 25'sd466945;
      4:  r = 25'sd234379;
      5:  r = 25'sd117304;
      6:  r = 25'sd58666;
      7:  r = 25'sd29335;
      8:  r = 25'sd14668;
      9:  r = 25'sd7334;
      10: r = 25'sd3667;
      11: r = 25'sd1833;
      12: r = 25'sd917;
      13: r = 25'sd458;
      14: r = 25'sd229;
      15: r = 25'sd115;
      16: r = 25'sd57;
      17: r = 25'sd29;
      18: r = 25'sd14;
      19: r = 25'sd7;
      20: r = 25'sd4;
      21: r = 25'sd2;
      22: r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // shift right rounding toward zero
  function automatic logic signed [CX_W-1:0] tshr(input logic signed [CX_W-1:0] v,
                                                  input int s);
    logic signed [CX_W-1:0] m;
    m = v[CX_W-1] ? -v : v;
    m = m >>> s;
    return v[CX_W-1] ? -m : m;
  endfunction

endpackage

// ===== rtl/tlik_front.sv =====
// Front end: squares, reach test and law-of-cosines numerators, three stages.
// Depends on tlik_pkg.
module tlik_front import tlik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic [XW-1:0]        x,
  input  logic signed [YW-1:0] y,
  input  logic [LW-1:0]        l1,
  input  logic [LW-1:0]        l2,
  output logic                 item_valid,
  output item_t                item
);

  logic v1_r, v2_r, v3_r;

  logic [XW-1:0]   x1_r, x2c_r;
  logic [YW-1:0]   ay1_r, ay2_r;
  logic            yneg1_r, yneg2_r;
  logic [2*XW-1:0] xsq_r;
  logic [2*YW-1:0] ysq_r;
  logic [2*LW-1:0] l1sq_r, l2sq_r, l1l2_r;
  logic [31:0]     sumsq_r, diffsq_r, sumsq2_r, diffsq2_r;

  logic [2*YW-1:0]        h2_r;
  logic [DENW-1:0]        lsum_r, den_r;
  logic signed [DENW-1:0] ldiff_r;
  item_t                  item_r;

  logic signed [2*YW-1:0] ys;
  logic [LW:0]            lsum16;
  logic signed [31:0]     ld32;

  always_comb begin
    ys     = (2*YW)'(y);
    lsum16 = (LW+1)'(l1) + (LW+1)'(l2);
    ld32   = $signed(32'(l1)) - $signed(32'(l2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: products
    x1_r     <= x;
    yneg1_r  <= y[YW-1];
    ay1_r    <= y[YW-1] ? YW'(-y) : YW'(y);
    xsq_r    <= (2*XW)'(x) * (2*XW)'(x);
    ysq_r    <= ys * ys;
    l1sq_r   <= (2*LW)'(l1) * (2*LW)'(l1);
    l2sq_r   <= (2*LW)'(l2) * (2*LW)'(l2);
    l1l2_r   <= (2*LW)'(l1) * (2*LW)'(l2);
    sumsq_r  <= 32'(lsum16) * 32'(lsum16);
    diffsq_r <= ld32 * ld32;
    // stage 2: sums
    h2_r      <= (2*YW)'(xsq_r) + ysq_r;
    lsum_r    <= DENW'(l1sq_r) + DENW'(l2sq_r);
    ldiff_r   <= $signed(DENW'(l1sq_r)) - $signed(DENW'(l2sq_r));
    den_r     <= {l1l2_r, 1'b0};
    sumsq2_r  <= sumsq_r;
    diffsq2_r <= diffsq_r;
    x2c_r     <= x1_r;
    ay2_r     <= ay1_r;
    yneg2_r   <= yneg1_r;
    // stage 3: classify
    item_r.reach <= (h2_r != '0) && (h2_r <= (2*YW)'(sumsq2_r))
                    && (h2_r >= (2*YW)'(diffsq2_r));
    item_r.num_e <= $signed(NUMW'(lsum_r)) - $signed(NUMW'(h2_r));
    item_r.num_s <= NUMW'(ldiff_r) + $signed(NUMW'(h2_r));
    item_r.den   <= den_r;
    item_r.tx    <= x2c_r;
    item_r.ay    <= ay2_r;
    item_r.yneg  <= yneg2_r;
  end

  assign item_valid = v3_r;
  assign item       = item_r;

endmodule

// ===== rtl/tlik_queue.sv =====
// Two-entry queue between the front end and the solver back end.
// Depends on tlik_pkg.
module tlik_queue import tlik_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output item_t dout,
  output logic  empty,
  output logic  full
);

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !full) cnt_nxt = cnt_nxt + 2'd1;
    if (pop && !empty) cnt_nxt = cnt_nxt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  assign dout  = mem_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule

// ===== rtl/tlik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on tlik_pkg.
module tlik_isqrt import tlik_pkg::*; (
  input  logic             clk,
  input  logic [RADW-1:0]  rad,
  output logic [ROOTW-1:0] root
);

  logic [RADW-1:0] v_in [ISQ_STAGES];
  logic [RADW-1:0] r_in [ISQ_STAGES];
  logic [RADW-1:0] v_r  [ISQ_STAGES];
  logic [RADW-1:0] r_r  [ISQ_STAGES];

  assign v_in[0] = rad;
  assign r_in[0] = '0;

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    localparam logic [RADW-1:0] BIT = RADW'(1) << (RADW - 2 - 2 * k);
    logic [RADW-1:0] t;
    if (k > 0) begin : g_link
      assign v_in[k] = v_r[k-1];
      assign r_in[k] = r_r[k-1];
    end
    assign t = r_in[k] + BIT;
    always_ff @(posedge clk) begin
      if (v_in[k] >= t) begin
        v_r[k] <= v_in[k] - t;
        r_r[k] <= (r_in[k] >> 1) + BIT;
      end else begin
        v_r[k] <= v_in[k];
        r_r[k] <= r_in[k] >> 1;
      end
    end
  end

  assign root = r_r[ISQ_STAGES-1][ROOTW-1:0];

endmodule

// ===== rtl/tlik_cordic.sv =====
// Pipelined vectoring CORDIC: first-quadrant atan2(b, a) in 2^-16 degree, 0..90.
// Depends on tlik_pkg. Input and output are registered.
module tlik_cordic import tlik_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic            clk,
  input  logic [NUMW-1:0] a,
  input  logic [NUMW-1:0] b,
  output logic [ZW-2:0]   angle
);

  logic signed [CX_W-1:0] x_r [STAGES+1];
  logic signed [CX_W-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0]   z_r [STAGES+1];
  logic                   za_r [STAGES+1];
  logic                   zb_r [STAGES+1];
  logic [ZW-2:0]          angle_r;

  always_ff @(posedge clk) begin
    x_r[0]  <= $signed(CX_W'({a, PRESHIFT'(0)}));
    y_r[0]  <= $signed(CX_W'({b, PRESHIFT'(0)}));
    z_r[0]  <= '0;
    za_r[0] <= (a == '0);
    zb_r[0] <= (b == '0);
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + tshr(y_r[i], i);
        y_r[i+1] <= y_r[i] - tshr(x_r[i], i);
        z_r[i+1] <= z_r[i] + atan_lut(i);
      end else begin
        x_r[i+1] <= x_r[i] - tshr(y_r[i], i);
        y_r[i+1] <= y_r[i] + tshr(x_r[i], i);
        z_r[i+1] <= z_r[i] - atan_lut(i);
      end
      za_r[i+1] <= za_r[i];
      zb_r[i+1] <= zb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (zb_r[STAGES])
      angle_r <= '0;
    else if (za_r[STAGES] || z_r[STAGES] > DEG90)
      angle_r <= DEG90[ZW-2:0];
    else if (z_r[STAGES] < 0)
      angle_r <= '0;
    else
      angle_r <= z_r[STAGES][ZW-2:0];
  end

  assign angle = angle_r;

endmodule

// ===== rtl/tlik_back.sv =====
// Back end: triangle area root, three CORDIC units and angle rounding.
// Depends on tlik_pkg, tlik_isqrt, tlik_cordic.
module tlik_back import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  item_t            in_item,
  output logic             out_valid,
  output logic [SHW-1:0]   shoulder,
  output logic [ELW-1:0]   elbow,
  output logic             reach
);

  localparam int SD = 3 + ISQ_STAGES;     // side line up to the root
  localparam int CL = CORDIC_STAGES + 2;  // side line through the CORDIC units
  localparam int SH = 16 - ANGLE_FRAC_BITS;
  localparam int OW = 27;
  localparam logic signed [OW-1:0] BIAS_RND = OW'(360 * 65536 + (1 << (SH - 1)));
  localparam logic signed [OW-1:0] OFF = OW'(360 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic reach;
    logic neg_e;
    logic neg_s;
    logic yneg;
  } cside_t;

  item_t     side_r [SD];
  logic [SD-1:0] sv_r;
  cside_t    cs_r [CL];
  logic [CL-1:0] cv_r;

  logic [DENW-1:0]  ae_r;
  logic [RADW-1:0]  ne2_r, den2_r, rad_r;
  logic [ROOTW-1:0] root;

  logic signed [NUMW-1:0] abs_e, abs_s;
  logic [NUMW-1:0] ca_e, ca_s, cb_s, cx, cy;
  logic [ZW-2:0]   ze, zs, zo;

  logic signed [ZW:0] ez_r, iz_r, oz_r;
  logic               p1v_r, p1r_r;
  logic               ov_r, or_r;
  logic [SHW-1:0]     sh_out_r;
  logic [ELW-1:0]     el_out_r;
  logic signed [OW-1:0] sb, eb;

  always_comb begin
    abs_e = in_item.num_e[NUMW-1] ? -in_item.num_e : in_item.num_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= '0;
      cv_r  <= '0;
      p1v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      sv_r  <= {sv_r[SD-2:0], in_valid};
      cv_r  <= {cv_r[CL-2:0], sv_r[SD-1]};
      p1v_r <= cv_r[CL-1];
      ov_r  <= p1v_r;
    end
  end

  // side-band delay lines
  always_ff @(posedge clk) begin
    side_r[0] <= in_item;
    for (int k = 1; k < SD; k++) side_r[k] <= side_r[k-1];
    cs_r[0].reach <= side_r[SD-1].reach;
    cs_r[0].neg_e <= side_r[SD-1].num_e[NUMW-1];
    cs_r[0].neg_s <= side_r[SD-1].num_s[NUMW-1];
    cs_r[0].yneg  <= side_r[SD-1].yneg;
    for (int k = 1; k < CL; k++) cs_r[k] <= cs_r[k-1];
  end

  // radicand: (2 l1 l2)^2 - num_e^2, zero when out of reach
  always_ff @(posedge clk) begin
    ae_r   <= in_item.reach ? abs_e[DENW-1:0] : '0;
    ne2_r  <= RADW'(ae_r) * RADW'(ae_r);
    den2_r <= RADW'(side_r[0].den) * RADW'(side_r[0].den);
    rad_r  <= (side_r[1].reach && ne2_r < den2_r) ? den2_r - ne2_r : '0;
  end

  tlik_isqrt u_isqrt (
    .clk  (clk),
    .rad  (rad_r),
    .root (root)
  );

  always_comb begin
    abs_s = side_r[SD-1].num_s[NUMW-1] ? -side_r[SD-1].num_s : side_r[SD-1].num_s;
    ca_e  = side_r[SD-1].num_e[NUMW-1] ? NUMW'(-side_r[SD-1].num_e)
                                       : NUMW'(side_r[SD-1].num_e);
    ca_s  = NUMW'(abs_s);
    cb_s  = NUMW'(root);
    cx    = NUMW'(side_r[SD-1].tx);
    cy    = NUMW'(side_r[SD-1].ay);
  end

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_e (
    .clk (clk), .a (ca_e), .b (cb_s), .angle (ze)
  );
  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_s (
    .clk (clk), .a (ca_s), .b (cb_s), .angle (zs)
  );
  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_o (
    .clk (clk), .a (cx), .b (cy), .angle (zo)
  );

  // fold into half plane, sign the target bearing
  always_ff @(posedge clk) begin
    ez_r  <= cs_r[CL-1].neg_e ? (ZW+1)'(DEG180) - (ZW+1)'(ze) : (ZW+1)'(ze);
    iz_r  <= cs_r[CL-1].neg_s ? (ZW+1)'(DEG180) - (ZW+1)'(zs) : (ZW+1)'(zs);
    oz_r  <= cs_r[CL-1].yneg ? -(ZW+1)'(zo) : (ZW+1)'(zo);
    p1r_r <= cs_r[CL-1].reach;
  end

  // round half up to output units
  always_comb begin
    sb = OW'(iz_r) + OW'(oz_r) + BIAS_RND;
    eb = OW'(ez_r) + BIAS_RND;
  end

  always_ff @(posedge clk) begin
    sh_out_r <= SHW'((sb >>> SH) - OFF);
    el_out_r <= ELW'((eb >>> SH) - OFF);
    or_r     <= p1r_r;
  end

  assign out_valid = ov_r;
  assign shoulder  = sh_out_r;
  assign elbow     = el_out_r;
  assign reach     = or_r;

endmodule

// ===== rtl/two_link_inverse_kinematics.sv =====
// Two-link planar arm inverse kinematics, top level: link registers, front, queue, back.
// Depends on tlik_pkg, tlik_front, tlik_queue, tlik_back.
//
// Takes one target point per clock cycle while busy is low. A point accepted at a clock
// edge (start high, busy low) comes out on out_valid and the result ports for one cycle;
// the receiver has no way to hold it. Its path runs through the 31-stage square root of
// the triangle area term followed by the CORDIC pipeline. busy only rises if the back
// end falls behind, which it does not. Link lengths must only be written through
// cfg_we/cfg_index/cfg_data while no point is in flight; the block does not enforce it.
module two_link_inverse_kinematics import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [XW-1:0]        in_target_x,
  input  logic signed [YW-1:0] in_target_y,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [LW-1:0]        cfg_data,
  output logic                 out_valid,
  output logic signed [SHW-1:0] out_shoulder_angle,
  output logic [ELW-1:0]       out_elbow_angle,
  output logic                 out_reachable
);

  localparam int LAT = CORDIC_STAGES + 42;

  logic [LW-1:0] upper_r, lower_r;
  logic          f_valid, q_empty, q_full;
  item_t         f_item, q_item;
  logic [SHW-1:0] shoulder;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= LINK_RESET;
      lower_r <= LINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER: upper_r <= cfg_data;
        CFG_LOWER: lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tlik_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (start && !busy),
    .x          (in_target_x),
    .y          (in_target_y),
    .l1         (upper_r),
    .l2         (lower_r),
    .item_valid (f_valid),
    .item       (f_item)
  );

  tlik_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .din   (f_item),
    .pop   (!q_empty),
    .dout  (q_item),
    .empty (q_empty),
    .full  (q_full)
  );

  tlik_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_empty),
    .in_item   (q_item),
    .out_valid (out_valid),
    .shoulder  (shoulder),
    .elbow     (out_elbow_angle),
    .reach     (out_reachable)
  );

  assign busy               = q_full;
  assign out_shoulder_angle = $signed(shoulder);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after fixed latency");

  a_no_backlog: assert property (@(posedge clk) disable iff (!rst_n) !q_full)
    else $error("queue filled up");

  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_elbow_angle <= ELW'(180 << ANGLE_FRAC_BITS)))
    else $error("elbow angle beyond 180 degrees");

endmodule
